// ===== src/scse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the square channel with sweep and envelope.
// No dependencies; imported by square_channel_sweep_envelope_unit.
package scse_pkg;

  typedef logic [2:0] mode_t;
  typedef logic [2:0] offset_t;

  localparam mode_t MODE_READ    = 3'd0;
  localparam mode_t MODE_WRITE   = 3'd1;
  localparam mode_t MODE_ADVANCE = 3'd2;
  localparam mode_t MODE_LENGTH  = 3'd3;
  localparam mode_t MODE_ENV     = 3'd4;
  localparam mode_t MODE_SWEEP   = 3'd5;

  localparam offset_t OFF_SWEEP  = 3'd0;
  localparam offset_t OFF_DUTY   = 3'd1;
  localparam offset_t OFF_ENV    = 3'd2;
  localparam offset_t OFF_FLOW   = 3'd3;
  localparam offset_t OFF_FHIGH  = 3'd4;

  localparam logic [7:0] RST_SWEEP = 8'h80;
  localparam logic [7:0] RST_DUTY  = 8'hBF;
  localparam logic [7:0] RST_ENV   = 8'hF3;
  localparam logic [7:0] RST_FHIGH = 8'hBF;

  localparam logic [7:0] MASK_SWEEP = 8'h80;
  localparam logic [7:0] MASK_DUTY  = 8'h3F;
  localparam logic [7:0] MASK_FLOW  = 8'hFF;
  localparam logic [7:0] MASK_FHIGH = 8'hBF;

  localparam logic [11:0] FREQ_MAX   = 12'd2047;
  localparam logic [11:0] FREQ_SPAN  = 12'd2048;
  localparam logic [6:0]  LEN_FULL   = 7'd64;
  localparam logic [22:0] HZ_BASE    = 23'd131072;
  localparam logic [22:0] CLK_RATE   = 23'd4194304;

  localparam int unsigned DIV_NUM_W = 23;
  localparam int unsigned DIV_DEN_W = 18;
  localparam logic [4:0]  DIV_LAST  = 5'd22;

endpackage
`default_nettype wire

// ===== src/square_channel_sweep_envelope_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Square sound channel with frequency sweep, volume envelope and length counter.
// Depends on scse_pkg for codes, reset values and divider sizes.

// One transaction is taken at a time and returns exactly one result. After
// acceptance the S_EXEC state applies the register and counter updates, then
// a single shared 23-step restoring divider (one quotient bit per cycle) does
// the work: a frequency reload takes two divisions (hz, then period), an
// advance takes one modulo, and every transaction ends with one division for
// the duty step, skipped when an eighth of the period is zero. The modulo of
// an advance is likewise skipped while the period is zero. The input is ready
// again in the cycle after the result is taken; a new transaction is not
// accepted while one is in flight.
module square_channel_sweep_envelope_unit (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire  scse_pkg::mode_t   in_mode,
  input  wire  scse_pkg::offset_t in_reg_offset,
  input  wire  [7:0]            in_write_data,
  input  wire  [7:0]            in_cycles,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [7:0]            out_read_data,
  output logic                  out_channel_on,
  output logic [3:0]            out_volume,
  output logic [1:0]            out_duty_select,
  output logic [2:0]            out_duty_step
);
  import scse_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_HZ   = 3'd2;
  localparam logic [2:0] S_PER  = 3'd3;
  localparam logic [2:0] S_MOD  = 3'd4;
  localparam logic [2:0] S_STEP = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]  state_r, state_nxt;
  mode_t       mode_r, mode_nxt;
  offset_t     off_r, off_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [7:0]  cyc_r, cyc_nxt;
  logic [7:0]  rd_r, rd_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        clamp_r, clamp_nxt;

  logic [7:0]  sweep_reg_r, sweep_reg_nxt;
  logic [7:0]  duty_reg_r, duty_reg_nxt;
  logic [7:0]  env_reg_r, env_reg_nxt;
  logic [7:0]  flow_reg_r, flow_reg_nxt;
  logic [7:0]  fhigh_reg_r, fhigh_reg_nxt;
  logic        enabled_r, enabled_nxt;
  logic [10:0] freq_value_r, freq_value_nxt;
  logic [16:0] period_r, period_nxt;
  logic [16:0] phase_r, phase_nxt;
  logic [6:0]  len_left_r, len_left_nxt;
  logic        len_en_r, len_en_nxt;
  logic [3:0]  vol_r, vol_nxt;
  logic        env_active_r, env_active_nxt;
  logic        env_up_r, env_up_nxt;
  logic [2:0]  env_period_r, env_period_nxt;
  logic [2:0]  env_left_r, env_left_nxt;
  logic [10:0] shadow_r, shadow_nxt;
  logic        sw_active_r, sw_active_nxt;
  logic        sw_up_r, sw_up_nxt;
  logic [2:0]  sw_period_r, sw_period_nxt;
  logic [2:0]  sw_left_r, sw_left_nxt;
  logic [2:0]  sw_shift_r, sw_shift_nxt;
  logic        zombie_r, zombie_nxt;

  // Shared divider datapath: quotient bits shift into the dividend register.
  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [4:0]           cnt_r, cnt_nxt;
  logic [DIV_DEN_W:0]   trial;
  logic                 div_ge;
  logic [DIV_DEN_W-1:0] rem_it;
  logic [DIV_NUM_W-1:0] num_it;

  assign trial  = {rem_r, num_r[DIV_NUM_W-1]};
  assign div_ge = trial >= {1'b0, den_r};
  assign rem_it = div_ge ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
  assign num_it = {num_r[DIV_NUM_W-2:0], div_ge};

  function automatic logic [11:0] swept(input logic [10:0] f, input logic up,
                                        input logic [2:0] sh);
    logic [11:0] delta;
    delta = {1'b0, f >> sh};
    swept = up ? ({1'b0, f} + delta) : ({1'b0, f} - delta);
  endfunction

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_read_data   = rd_r;
  assign out_channel_on  = enabled_r;
  assign out_volume      = vol_r;
  assign out_duty_select = duty_reg_r[7:6];
  assign out_duty_step   = step_r;

  always_comb begin
    logic        need_per;
    logic [10:0] f;
    logic        go_step;
    logic [16:0] st_per;
    logic [16:0] st_ph;
    logic [13:0] eighth;
    logic [6:0]  ll;
    logic [2:0]  el;
    logic [3:0]  nv;
    logic [2:0]  sl;
    logic [11:0] nf;
    logic [16:0] per_q;
    logic [17:0] sum;

    state_nxt = state_r;
    mode_nxt = mode_r;
    off_nxt = off_r;
    data_nxt = data_r;
    cyc_nxt = cyc_r;
    rd_nxt = rd_r;
    step_nxt = step_r;
    clamp_nxt = clamp_r;
    sweep_reg_nxt = sweep_reg_r;
    duty_reg_nxt = duty_reg_r;
    env_reg_nxt = env_reg_r;
    flow_reg_nxt = flow_reg_r;
    fhigh_reg_nxt = fhigh_reg_r;
    enabled_nxt = enabled_r;
    freq_value_nxt = freq_value_r;
    period_nxt = period_r;
    phase_nxt = phase_r;
    len_left_nxt = len_left_r;
    len_en_nxt = len_en_r;
    vol_nxt = vol_r;
    env_active_nxt = env_active_r;
    env_up_nxt = env_up_r;
    env_period_nxt = env_period_r;
    env_left_nxt = env_left_r;
    shadow_nxt = shadow_r;
    sw_active_nxt = sw_active_r;
    sw_up_nxt = sw_up_r;
    sw_period_nxt = sw_period_r;
    sw_left_nxt = sw_left_r;
    sw_shift_nxt = sw_shift_r;
    zombie_nxt = zombie_r;
    num_nxt = num_r;
    den_nxt = den_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;

    need_per = 1'b0;
    f = freq_value_r;
    go_step = 1'b0;
    st_per = period_r;
    st_ph = phase_r;
    eighth = '0;
    ll = '0;
    el = '0;
    nv = '0;
    sl = '0;
    nf = '0;
    per_q = '0;
    sum = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt = in_mode;
          off_nxt = in_reg_offset;
          data_nxt = in_write_data;
          cyc_nxt = in_cycles;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        rd_nxt = '0;
        clamp_nxt = 1'b0;
        case (mode_r)
          MODE_READ: begin
            case (off_r)
              OFF_SWEEP: rd_nxt = sweep_reg_r | MASK_SWEEP;
              OFF_DUTY:  rd_nxt = duty_reg_r | MASK_DUTY;
              OFF_ENV:   rd_nxt = env_reg_r;
              OFF_FLOW:  rd_nxt = MASK_FLOW;
              OFF_FHIGH: rd_nxt = fhigh_reg_r | MASK_FHIGH;
              default:   rd_nxt = '0;
            endcase
          end

          MODE_WRITE: begin
            case (off_r)
              OFF_SWEEP: sweep_reg_nxt = data_r;
              OFF_DUTY: begin
                duty_reg_nxt = data_r;
                len_left_nxt = LEN_FULL - {1'b0, data_r[5:0]};
                len_en_nxt = fhigh_reg_r[6];
              end
              OFF_ENV: begin
                env_reg_nxt = data_r;
                if (zombie_r && (data_r[7:4] == 4'd0)) begin
                  enabled_nxt = 1'b0;
                end
              end
              OFF_FLOW: begin
                flow_reg_nxt = data_r;
                if (flow_reg_r != data_r) begin
                  f = {fhigh_reg_r[2:0], data_r};
                  freq_value_nxt = f;
                  need_per = 1'b1;
                  clamp_nxt = 1'b1;
                end
              end
              OFF_FHIGH: begin
                fhigh_reg_nxt = data_r;
                f = {data_r[2:0], flow_reg_r};
                if (data_r[7]) begin
                  // Trigger: reload the length, envelope and sweep counters and the frequency from the registers.
                  enabled_nxt = 1'b1;
                  len_left_nxt = LEN_FULL - {1'b0, duty_reg_r[5:0]};
                  len_en_nxt = data_r[6];
                  freq_value_nxt = f;
                  need_per = 1'b1;
                  clamp_nxt = 1'b1;
                  vol_nxt = env_reg_r[7:4];
                  env_up_nxt = env_reg_r[3];
                  env_period_nxt = env_reg_r[2:0];
                  env_left_nxt = env_reg_r[2:0];
                  env_active_nxt = (env_reg_r[2:0] != 3'd0);
                  shadow_nxt = f;
                  sw_up_nxt = ~sweep_reg_r[3];
                  sw_period_nxt = sweep_reg_r[6:4];
                  sw_left_nxt = sweep_reg_r[6:4];
                  sw_shift_nxt = sweep_reg_r[2:0];
                  sw_active_nxt = (sweep_reg_r[6:4] != 3'd0) || (sweep_reg_r[2:0] != 3'd0);
                  if (sw_active_nxt &&
                      ((swept(f, ~sweep_reg_r[3], sweep_reg_r[2:0]) > FREQ_MAX) ||
                       (sweep_reg_r[2:0] == 3'd0))) begin
                    enabled_nxt = 1'b0;
                  end
                  zombie_nxt = 1'b0;
                end else if (fhigh_reg_r[2:0] != data_r[2:0]) begin
                  freq_value_nxt = f;
                  need_per = 1'b1;
                  clamp_nxt = 1'b1;
                end
              end
              default: ;
            endcase
          end

          MODE_LENGTH: begin
            if (enabled_r && len_en_r) begin
              ll = len_left_r - 7'd1;
              len_left_nxt = ll;
              if (ll == 7'd0) begin
                enabled_nxt = 1'b0;
              end
            end
          end

          MODE_ENV: begin
            if (env_active_r) begin
              el = env_left_r - 3'd1;
              env_left_nxt = el;
              if (el == 3'd0) begin
                if (env_up_r) begin
                  nv = (vol_r < 4'd15) ? vol_r + 4'd1 : vol_r;
                  if (nv == 4'd15) begin
                    env_active_nxt = 1'b0;
                    zombie_nxt = 1'b1;
                  end
                end else begin
                  nv = (vol_r > 4'd0) ? vol_r - 4'd1 : vol_r;
                  if (nv == 4'd0) begin
                    env_active_nxt = 1'b0;
                    zombie_nxt = 1'b1;
                  end
                end
                vol_nxt = nv;
                env_left_nxt = env_period_r;
              end
            end
          end

          MODE_SWEEP: begin
            if (sw_active_r && (sw_period_r != 3'd0)) begin
              sl = sw_left_r - 3'd1;
              sw_left_nxt = sl;
              if (sl == 3'd0) begin
                nf = swept(shadow_r, sw_up_r, sw_shift_r);
                if ((nf <= FREQ_MAX) && (sw_shift_r != 3'd0)) begin
                  f = nf[10:0];
                  flow_reg_nxt = nf[7:0];
                  fhigh_reg_nxt = {fhigh_reg_r[7:6], 3'b000, nf[10:8]};
                  shadow_nxt = nf[10:0];
                  need_per = 1'b1;
                  if (swept(nf[10:0], sw_up_r, sw_shift_r) > FREQ_MAX) begin
                    enabled_nxt = 1'b0;
                  end
                end else begin
                  enabled_nxt = 1'b0;
                end
                sw_left_nxt = sw_period_r;
              end
            end
          end

          default: ;
        endcase

        if (need_per) begin
          num_nxt = HZ_BASE;
          den_nxt = DIV_DEN_W'(FREQ_SPAN - {1'b0, f});
          rem_nxt = '0;
          cnt_nxt = '0;
          state_nxt = S_HZ;
        end else if (mode_r == MODE_ADVANCE) begin
          if (period_r == 17'd0) begin
            phase_nxt = '0;
            st_ph = '0;
            go_step = 1'b1;
          end else begin
            sum = {1'b0, phase_r} + {10'd0, cyc_r};
            num_nxt = DIV_NUM_W'(sum);
            den_nxt = DIV_DEN_W'(period_r);
            rem_nxt = '0;
            cnt_nxt = '0;
            state_nxt = S_MOD;
          end
        end else begin
          go_step = 1'b1;
        end
      end

      S_HZ: begin
        num_nxt = num_it;
        rem_nxt = rem_it;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == DIV_LAST) begin
          num_nxt = CLK_RATE;
          den_nxt = num_it[DIV_DEN_W-1:0];
          rem_nxt = '0;
          cnt_nxt = '0;
          state_nxt = S_PER;
        end
      end

      S_PER: begin
        num_nxt = num_it;
        rem_nxt = rem_it;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == DIV_LAST) begin
          per_q = num_it[16:0];
          period_nxt = per_q;
          st_per = per_q;
          if (clamp_r && (per_q < phase_r)) begin
            phase_nxt = per_q;
            st_ph = per_q;
          end
          go_step = 1'b1;
        end
      end

      S_MOD: begin
        num_nxt = num_it;
        rem_nxt = rem_it;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == DIV_LAST) begin
          phase_nxt = rem_it[16:0];
          st_ph = rem_it[16:0];
          go_step = 1'b1;
        end
      end

      S_STEP: begin
        num_nxt = num_it;
        rem_nxt = rem_it;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == DIV_LAST) begin
          step_nxt = (num_it > DIV_NUM_W'(7)) ? 3'd7 : num_it[2:0];
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Duty step is phase over one eighth of the period, saturated at seven, or zero when that eighth is zero.
    if (go_step) begin
      eighth = st_per[16:3];
      if (eighth == 14'd0) begin
        step_nxt = '0;
        state_nxt = S_OUT;
      end else begin
        num_nxt = DIV_NUM_W'(st_ph);
        den_nxt = DIV_DEN_W'(eighth);
        rem_nxt = '0;
        cnt_nxt = '0;
        state_nxt = S_STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sweep_reg_r <= RST_SWEEP;
      duty_reg_r <= RST_DUTY;
      env_reg_r <= RST_ENV;
      flow_reg_r <= '0;
      fhigh_reg_r <= RST_FHIGH;
      enabled_r <= 1'b0;
      freq_value_r <= '0;
      period_r <= '0;
      phase_r <= '0;
      len_left_r <= '0;
      len_en_r <= 1'b0;
      vol_r <= '0;
      env_active_r <= 1'b0;
      env_up_r <= 1'b0;
      env_period_r <= '0;
      env_left_r <= '0;
      shadow_r <= '0;
      sw_active_r <= 1'b0;
      sw_up_r <= 1'b0;
      sw_period_r <= '0;
      sw_left_r <= '0;
      sw_shift_r <= '0;
      zombie_r <= 1'b0;
      rd_r <= '0;
      step_r <= '0;
      clamp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      sweep_reg_r <= sweep_reg_nxt;
      duty_reg_r <= duty_reg_nxt;
      env_reg_r <= env_reg_nxt;
      flow_reg_r <= flow_reg_nxt;
      fhigh_reg_r <= fhigh_reg_nxt;
      enabled_r <= enabled_nxt;
      freq_value_r <= freq_value_nxt;
      period_r <= period_nxt;
      phase_r <= phase_nxt;
      len_left_r <= len_left_nxt;
      len_en_r <= len_en_nxt;
      vol_r <= vol_nxt;
      env_active_r <= env_active_nxt;
      env_up_r <= env_up_nxt;
      env_period_r <= env_period_nxt;
      env_left_r <= env_left_nxt;
      shadow_r <= shadow_nxt;
      sw_active_r <= sw_active_nxt;
      sw_up_r <= sw_up_nxt;
      sw_period_r <= sw_period_nxt;
      sw_left_r <= sw_left_nxt;
      sw_shift_r <= sw_shift_nxt;
      zombie_r <= zombie_nxt;
      rd_r <= rd_nxt;
      step_r <= step_nxt;
      clamp_r <= clamp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    off_r <= off_nxt;
    data_r <= data_nxt;
    cyc_r <= cyc_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

endmodule
`default_nettype wire
